>>> rtl/vssr_pkg.sv
// vssr_pkg: shared widths, codes and types of the vector statistics block
// used by every module of the block, depends on nothing
`default_nettype none

package vssr_pkg;

    localparam int SAMPLE_W        = 24;
    localparam int SUM_W           = 36;
    localparam int SQ_W            = 59;
    localparam int STEP_W          = 61;
    localparam int PROD_W          = 72;
    localparam int RAD_W           = 64;
    localparam int ROOT_W          = 32;
    localparam int OPB_W           = 36;
    localparam int CNT_OUT_W       = 13;
    localparam int MINPOS_W        = 23;
    localparam int RMS_W           = 25;
    localparam int FACT_W          = 4;
    localparam int SKIP_W          = 6;
    localparam int CFG_W           = 6;
    localparam int SKIP_MAX        = 63;
    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 304;

    localparam logic [FACT_W-1:0] FACT_RST = 4'd7;
    localparam logic [SKIP_W-1:0] SKIP_RST = 6'd20;

    typedef enum logic {
        CFG_SPIKE_FACTOR = 1'b0,
        CFG_SKIP_LENGTH  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_arith_op;

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_MUL_NS2, S_MUL_SS, S_DIV_VAR, S_SQ_VAR, S_DIV_AVG, S_DIV_MS,
        S_SQ_RMS, S_MUL_LIM, S_RD, S_CHK, S_SQR, S_MULN, S_DEC, S_JRD, S_JCHK,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        t_arith_op           op;
        logic [PROD_W-1:0]   a;
        logic [OPB_W-1:0]    b;
    } t_arith_req;

    typedef struct packed {
        logic                       ok;
        logic signed [SAMPLE_W-1:0] val;
    } t_entry;

    typedef struct packed {
        logic signed [SUM_W-1:0]    sum;
        logic [SQ_W-1:0]            sq;
        logic [STEP_W-1:0]          step;
        logic signed [SAMPLE_W-1:0] vmax;
        logic signed [SAMPLE_W-1:0] vmin;
        logic signed [SAMPLE_W-1:0] minpos;
        logic                       rising;
    } t_stats;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  clean_min;
        logic [SAMPLE_W-1:0]  clean_max;
        logic                 rising;
        logic [CNT_OUT_W-1:0] valid_count;
        logic [RMS_W-1:0]     root_mean_square;
        logic [SAMPLE_W-1:0]  deviation;
        logic [SAMPLE_W-1:0]  average;
        logic [MINPOS_W-1:0]  least_positive;
        logic [SAMPLE_W-1:0]  smallest;
        logic [SAMPLE_W-1:0]  largest;
        logic [SQ_W-1:0]      total_squares;
        logic [SUM_W-1:0]     total;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/vssr_store.sv
// vssr_store: sample store, one write port and one read port, registered read
// depends on vssr_pkg
`default_nettype none

module vssr_store
    import vssr_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    localparam int AW = $clog2(MAX_SAMPLES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [MAX_SAMPLES];
    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

>>> rtl/vssr_arith.sv
// vssr_arith: shared iterative unit, shift-add multiply, restoring divide
// and bitwise square root; depends on vssr_pkg
`default_nettype none

module vssr_arith
    import vssr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_arith_req i_req,
    output logic            o_done,
    output logic [PROD_W-1:0] o_result
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic              r_busy, r_done;
    t_arith_op         r_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0] r_a, n_a;
    logic [OPB_W-1:0]  r_b, n_b;
    logic [PROD_W-1:0] r_p, n_p;
    logic [OPB_W:0]    r_rem, n_rem;
    logic [OPB_W:0]    w_dv_t, w_sq_t, w_trial;

    assign w_dv_t  = {r_rem[OPB_W-1:0], r_a[PROD_W-1]};
    assign w_sq_t  = {r_rem[OPB_W-2:0], r_a[RAD_W-1:RAD_W-2]};
    assign w_trial = {3'b0, r_p[ROOT_W-1:0], 2'b01};

    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_p   = r_p;
        n_rem = r_rem;
        n_cnt = r_cnt - CNT_W'(1);
        unique case (r_op)
            OP_MUL: begin
                if (r_b[0]) begin
                    n_p = r_p + r_a;
                end
                n_a = r_a << 1;
                n_b = r_b >> 1;
            end
            OP_DIV: begin
                // one quotient bit a step
                if (w_dv_t >= {1'b0, r_b}) begin
                    n_rem = w_dv_t - {1'b0, r_b};
                    n_p   = {r_p[PROD_W-2:0], 1'b1};
                end else begin
                    n_rem = w_dv_t;
                    n_p   = {r_p[PROD_W-2:0], 1'b0};
                end
                n_a = r_a << 1;
            end
            OP_SQRT: begin
                // two radicand bits in, one root bit out
                if (w_sq_t >= w_trial) begin
                    n_rem = w_sq_t - w_trial;
                    n_p   = {r_p[PROD_W-2:0], 1'b1};
                end else begin
                    n_rem = w_sq_t;
                    n_p   = {r_p[PROD_W-2:0], 1'b0};
                end
                n_a = r_a << 2;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_req.op;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_p   <= '0;
            r_rem <= '0;
            priority case (i_req.op)
                OP_MUL:  r_cnt <= CNT_W'(OPB_W);
                OP_DIV:  r_cnt <= CNT_W'(PROD_W);
                default: r_cnt <= CNT_W'(ROOT_W);
            endcase
        end else if (r_busy) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_p   <= n_p;
            r_rem <= n_rem;
            r_cnt <= n_cnt;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_p;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("arith start while busy");

endmodule

`default_nettype wire

>>> rtl/vssr_accum.sv
// vssr_accum: running sums, extremes and flags folded in while samples load
// depends on vssr_pkg
`default_nettype none

module vssr_accum
    import vssr_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_ok,
    input  wire logic                       i_clear,
    output t_stats                          o_stats,
    output logic [CW-1:0]                   o_count,
    output logic [CW-1:0]                   o_n,
    output logic                            o_full
);

    localparam int SQP_W = 2 * SAMPLE_W;

    logic [CW-1:0]              r_count, r_n;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]            r_sq;
    logic [STEP_W-1:0]          r_step;
    logic signed [SAMPLE_W-1:0] r_max, r_min, r_minpos, r_prev;
    logic                       r_rising, r_seen;

    logic [SAMPLE_W-1:0]        w_abs_v, w_abs_d;
    logic signed [SAMPLE_W:0]   w_d;
    logic [SQP_W-1:0]           w_vsq, w_dsq;
    logic                       w_take;

    assign o_full  = (r_count == CW'(MAX_SAMPLES));
    assign w_take  = i_accept && !o_full;
    assign w_abs_v = i_sample[SAMPLE_W-1] ? SAMPLE_W'(-i_sample) : i_sample;
    assign w_d     = {i_sample[SAMPLE_W-1], i_sample} - {r_prev[SAMPLE_W-1], r_prev};
    assign w_abs_d = w_d[SAMPLE_W] ? SAMPLE_W'(-w_d) : w_d[SAMPLE_W-1:0];
    assign w_vsq   = {{SAMPLE_W{1'b0}}, w_abs_v} * {{SAMPLE_W{1'b0}}, w_abs_v};
    assign w_dsq   = {{SAMPLE_W{1'b0}}, w_abs_d} * {{SAMPLE_W{1'b0}}, w_abs_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count  <= '0;
            r_n      <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
            r_step   <= '0;
            r_max    <= '0;
            r_min    <= '0;
            r_minpos <= '0;
            r_prev   <= '0;
            r_rising <= 1'b1;
            r_seen   <= 1'b0;
        end else if (w_take) begin
            r_count <= r_count + CW'(1);
            if (i_ok) begin
                if (r_seen) begin
                    r_step <= r_step + STEP_W'(w_dsq);
                    if (i_sample <= r_prev) begin
                        r_rising <= 1'b0;
                    end
                    if (i_sample > r_max) begin
                        r_max <= i_sample;
                    end
                    if (i_sample < r_min) begin
                        r_min <= i_sample;
                    end
                end else begin
                    r_max <= i_sample;
                    r_min <= i_sample;
                end
                if (i_sample > 0 && (r_minpos == 0 || i_sample < r_minpos)) begin
                    r_minpos <= i_sample;
                end
                r_seen <= 1'b1;
                r_prev <= i_sample;
                r_n    <= r_n + CW'(1);
                r_sum  <= r_sum + SUM_W'(i_sample);
                r_sq   <= r_sq + SQ_W'(w_vsq);
            end else begin
                r_rising <= 1'b0;
            end
        end
    end

    assign o_count        = r_count;
    assign o_n            = r_n;
    assign o_stats.sum    = r_sum;
    assign o_stats.sq     = r_sq;
    assign o_stats.step   = r_step;
    assign o_stats.vmax   = r_max;
    assign o_stats.vmin   = r_min;
    assign o_stats.minpos = r_minpos;
    assign o_stats.rising = r_rising;

endmodule

`default_nettype wire

>>> rtl/vssr_seq.sv
// vssr_seq: closing sequencer, mean/sigma/rms through the shared arith unit
// and the spike-rejecting pass over the store; depends on vssr_pkg
`default_nettype none

module vssr_seq
    import vssr_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int AW = $clog2(MAX_SAMPLES)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_stats             i_stats,
    input  wire logic [CW-1:0]      i_n,
    input  wire logic [CW-1:0]      i_cnt,
    input  wire logic [FACT_W-1:0]  i_factor,
    input  wire logic [SKIP_W-1:0]  i_skip,
    output logic                    o_astart,
    output t_arith_req              o_areq,
    input  wire logic               i_adone,
    input  wire logic [PROD_W-1:0]  i_ares,
    output logic                    o_rd_en,
    output logic [AW-1:0]           o_rd_addr,
    input  wire t_entry             i_rd_q,
    input  wire logic               i_out_free,
    output logic                    o_ready,
    output logic                    o_res_valid,
    output t_result                 o_res
);

    localparam int IW    = $clog2(MAX_SAMPLES + SKIP_MAX + 3);
    localparam int NN_W  = 2 * CW;
    localparam int D2_W  = 2 * SAMPLE_W;
    localparam int D2N_W = D2_W + CW;

    t_seq_state r_state, n_state;
    logic       r_issued, n_issued;
    logic       w_math;

    logic [PROD_W-1:0]          r_t, r_lim;
    logic [SAMPLE_W-1:0]        r_dev, r_avg;
    logic [RMS_W-1:0]           r_rms;
    logic [IW-1:0]              r_i, r_j;
    logic signed [SAMPLE_W-1:0] r_ref, r_cmax, r_cmin, r_v;
    logic                       r_have;
    logic [SAMPLE_W-1:0]        r_ad;
    logic [D2_W-1:0]            r_d2;
    logic [D2N_W-1:0]           r_d2n;

    logic [SUM_W-1:0]           w_abs_sum;
    logic [NN_W-1:0]            w_nn;
    logic [2*FACT_W-1:0]        w_ff;
    logic signed [SAMPLE_W-1:0] w_ref_eff;
    logic signed [SAMPLE_W:0]   w_d;
    logic [SAMPLE_W-1:0]        w_ad, w_q24;
    logic                       w_pass;
    logic [IW-1:0]              w_j, w_cnt;

    assign w_abs_sum = i_stats.sum[SUM_W-1] ? SUM_W'(-i_stats.sum) : i_stats.sum;
    assign w_nn      = {{CW{1'b0}}, i_n} * {{CW{1'b0}}, i_n - CW'(1)};
    assign w_ff      = {{FACT_W{1'b0}}, i_factor} * {{FACT_W{1'b0}}, i_factor};
    assign w_ref_eff = r_have ? r_ref : i_rd_q.val;
    assign w_d       = {i_rd_q.val[SAMPLE_W-1], i_rd_q.val}
                     - {w_ref_eff[SAMPLE_W-1], w_ref_eff};
    assign w_ad      = w_d[SAMPLE_W] ? SAMPLE_W'(-w_d) : w_d[SAMPLE_W-1:0];
    assign w_q24     = i_ares[SAMPLE_W-1:0];
    // step passes when d*d*n stays below factor^2 times the step-square sum
    assign w_pass    = PROD_W'(r_d2n) < r_lim;
    assign w_j       = r_i + IW'(i_skip);
    assign w_cnt     = IW'(i_cnt);

    assign w_math = r_state == S_MUL_NS2 || r_state == S_MUL_SS ||
                    r_state == S_DIV_VAR || r_state == S_SQ_VAR ||
                    r_state == S_DIV_AVG || r_state == S_DIV_MS ||
                    r_state == S_SQ_RMS  || r_state == S_MUL_LIM;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_issued    = w_math && (!r_issued || !i_adone);
        o_astart    = w_math && !r_issued;
        o_areq      = '{op: OP_MUL, a: '0, b: '0};
        o_rd_en     = 1'b0;
        o_rd_addr   = r_i[AW-1:0];
        o_res_valid = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                // the stats now include the closing sample
                n_state = (i_n >= CW'(2)) ? S_MUL_NS2 : S_SQ_RMS;
            end
            S_MUL_NS2: begin
                o_areq = '{op: OP_MUL, a: PROD_W'(i_stats.sq), b: OPB_W'(i_n)};
                if (i_adone) n_state = S_MUL_SS;
            end
            S_MUL_SS: begin
                o_areq = '{op: OP_MUL, a: PROD_W'(w_abs_sum), b: OPB_W'(w_abs_sum)};
                if (i_adone) n_state = S_DIV_VAR;
            end
            S_DIV_VAR: begin
                o_areq = '{op: OP_DIV, a: r_t, b: OPB_W'(w_nn)};
                if (i_adone) n_state = S_SQ_VAR;
            end
            S_SQ_VAR: begin
                o_areq = '{op: OP_SQRT, a: PROD_W'(r_t[RAD_W-1:0]), b: '0};
                if (i_adone) n_state = S_DIV_AVG;
            end
            S_DIV_AVG: begin
                o_areq = '{op: OP_DIV, a: PROD_W'(w_abs_sum), b: OPB_W'(i_n)};
                if (i_adone) n_state = S_DIV_MS;
            end
            S_DIV_MS: begin
                o_areq = '{op: OP_DIV, a: PROD_W'(i_stats.sq), b: OPB_W'(i_n)};
                if (i_adone) n_state = S_SQ_RMS;
            end
            S_SQ_RMS: begin
                o_areq = '{op: OP_SQRT, a: PROD_W'(r_t[RAD_W-1:0]), b: '0};
                if (i_adone) n_state = (i_n != '0) ? S_MUL_LIM : S_DONE;
            end
            S_MUL_LIM: begin
                o_areq = '{op: OP_MUL, a: PROD_W'(i_stats.step), b: OPB_W'(w_ff)};
                if (i_adone) n_state = S_RD;
            end
            S_RD: begin
                if (r_i >= w_cnt) begin
                    n_state = S_DONE;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = i_rd_q.ok ? S_SQR : S_RD;
            end
            S_SQR:  n_state = S_MULN;
            S_MULN: n_state = S_DEC;
            S_DEC: begin
                if (w_pass || w_j >= w_cnt) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_JRD;
                end
            end
            S_JRD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_j[AW-1:0];
                n_state   = S_JCHK;
            end
            S_JCHK: n_state = S_RD;
            S_DONE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    r_i    <= '0;
                    r_have <= 1'b0;
                    r_cmax <= '0;
                    r_cmin <= '0;
                    r_avg  <= '0;
                end
            end
            S_INIT: begin
                r_dev <= i_stats.vmax - i_stats.vmin;
                r_t   <= PROD_W'(i_stats.sq);
            end
            S_MUL_NS2, S_DIV_VAR, S_DIV_MS: begin
                if (i_adone) r_t <= i_ares;
            end
            S_MUL_SS: begin
                if (i_adone) r_t <= r_t - i_ares;
            end
            S_SQ_VAR: begin
                if (i_adone) r_dev <= w_q24;
            end
            S_DIV_AVG: begin
                if (i_adone) r_avg <= i_stats.sum[SUM_W-1] ? -w_q24 : w_q24;
            end
            S_SQ_RMS: begin
                if (i_adone) r_rms <= i_ares[RMS_W-1:0];
            end
            S_MUL_LIM: begin
                if (i_adone) r_lim <= i_ares;
            end
            S_CHK: begin
                if (i_rd_q.ok) begin
                    // first valid entry becomes reference and seeds the extremes
                    if (!r_have) begin
                        r_ref  <= i_rd_q.val;
                        r_cmax <= i_rd_q.val;
                        r_cmin <= i_rd_q.val;
                        r_have <= 1'b1;
                    end
                    r_ad <= w_ad;
                    r_v  <= i_rd_q.val;
                end else begin
                    r_i <= r_i + IW'(1);
                end
            end
            S_SQR: begin
                r_d2 <= {{SAMPLE_W{1'b0}}, r_ad} * {{SAMPLE_W{1'b0}}, r_ad};
            end
            S_MULN: begin
                r_d2n <= {{CW{1'b0}}, r_d2} * {{D2_W{1'b0}}, i_n};
            end
            S_DEC: begin
                if (w_pass) begin
                    if (r_v > r_cmax) begin
                        r_cmax <= r_v;
                    end else if (r_v < r_cmin) begin
                        r_cmin <= r_v;
                    end
                    r_ref <= r_v;
                    r_i   <= r_i + IW'(1);
                end else begin
                    // spike: jump past the skip window
                    r_j <= w_j;
                    r_i <= w_j + IW'(2);
                end
            end
            S_JCHK: begin
                if (i_rd_q.ok) r_ref <= i_rd_q.val;
            end
            default: begin
            end
        endcase
    end

    assign o_ready = (r_state == S_LOAD);

    assign o_res.total            = i_stats.sum;
    assign o_res.total_squares    = i_stats.sq;
    assign o_res.largest          = i_stats.vmax;
    assign o_res.smallest         = i_stats.vmin;
    assign o_res.least_positive   = i_stats.minpos[MINPOS_W-1:0];
    assign o_res.average          = r_avg;
    assign o_res.deviation        = r_dev;
    assign o_res.root_mean_square = r_rms;
    assign o_res.valid_count      = CNT_OUT_W'(i_n);
    assign o_res.rising           = i_stats.rising && (i_n != '0);
    assign o_res.clean_max        = r_cmax;
    assign o_res.clean_min        = r_cmin;

    a_chk_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHK |-> $past(r_state) == S_RD)
        else $error("entry checked without a read the cycle before");

    a_jchk_after_jrd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_JCHK |-> $past(r_state) == S_JRD)
        else $error("reference checked without a read the cycle before");

endmodule

`default_nettype wire

>>> rtl/vector_stats_spike_reject_unit.sv
// vector_stats_spike_reject_unit: statistics of one sample vector with a
// spike-rejecting max/min; depends on vssr_pkg, vssr_store, vssr_accum, vssr_arith, vssr_seq
// input: one sample per cycle while loading; the last sample closes the vector
// after the last sample: a setup state, then multiplies, divides and roots in the shared arith unit
// (if under two valid samples only the rms root, plus the limit multiply for one valid sample),
// then the clean pass over the stored samples and the commit; sync active-low reset
`default_nettype none

module vector_stats_spike_reject_unit
    import vssr_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write port: spike_factor, skip_length
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // sample request stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // sample[23:0], sample_valid[24]
    input  wire logic                 s_axis_tlast,
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // total, total_squares, largest, smallest, least_positive, average,
    // deviation, root_mean_square, valid_count, rising, clean_max, clean_min
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);

    // config registers: the user must write them only while the block is idle; the block does not enforce it
    logic [FACT_W-1:0] r_spike_factor;
    logic [SKIP_W-1:0] r_skip_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spike_factor <= FACT_RST;
            r_skip_length  <= SKIP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SPIKE_FACTOR: r_spike_factor <= i_cfg_data[FACT_W-1:0];
                CFG_SKIP_LENGTH:  r_skip_length  <= i_cfg_data[SKIP_W-1:0];
            endcase
        end
    end

    // input side
    logic   w_accept, w_full, w_clear, w_ready;
    t_entry w_wentry;
    t_stats w_stats;
    logic [CW-1:0] w_count, w_n;

    assign s_axis_tready = w_ready;
    assign w_accept      = s_axis_tvalid && w_ready;
    assign w_wentry.val  = s_axis_tdata[SAMPLE_W-1:0];
    assign w_wentry.ok   = s_axis_tdata[SAMPLE_W];

    vssr_accum #(.MAX_SAMPLES(MAX_SAMPLES)) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_sample (w_wentry.val),
        .i_ok     (w_wentry.ok),
        .i_clear  (w_clear),
        .o_stats  (w_stats),
        .o_count  (w_count),
        .o_n      (w_n),
        .o_full   (w_full)
    );

    // samples go into the store at the current count; a full store drops them
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_entry        w_rd_q;

    vssr_store #(.MAX_SAMPLES(MAX_SAMPLES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && !w_full),
        .i_waddr (w_count[AW-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_q)
    );

    // shared multiply / divide / root unit
    logic              w_astart, w_adone;
    t_arith_req        w_areq;
    logic [PROD_W-1:0] w_ares;

    vssr_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_astart),
        .i_req    (w_areq),
        .o_done   (w_adone),
        .o_result (w_ares)
    );

    // closing sequencer
    logic    w_res_valid, w_out_free;
    t_result w_res;

    vssr_seq #(.MAX_SAMPLES(MAX_SAMPLES)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept && s_axis_tlast),
        .i_stats     (w_stats),
        .i_n         (w_n),
        .i_cnt       (w_count),
        .i_factor    (r_spike_factor),
        .i_skip      (r_skip_length),
        .o_astart    (w_astart),
        .o_areq      (w_areq),
        .i_adone     (w_adone),
        .i_ares      (w_ares),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_q      (w_rd_q),
        .i_out_free  (w_out_free),
        .o_ready     (w_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // the result commit also clears the vector state
    assign w_clear = w_res_valid;

    // output register: loading a new vector goes on while a result waits here
    logic    r_out_valid;
    t_result r_out;

    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b0,
                            r_out.clean_min, r_out.clean_max, r_out.rising,
                            r_out.valid_count, r_out.root_mean_square,
                            r_out.deviation, r_out.average, r_out.least_positive,
                            r_out.smallest, r_out.largest, r_out.total_squares,
                            r_out.total};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (!r_out_valid || m_axis_tready))
        else $error("result committed over a waiting result");

endmodule

`default_nettype wire

>>> dv/vector_stats_spike_reject_unit_test.sv
// self-checking testbench of vector_stats_spike_reject_unit: sample vectors in, statistics out
// depends on vssr_pkg and the rtl of the unit; has its own predictor and results scoreboard
`timescale 1ns / 100ps

module vector_stats_spike_reject_unit_test;
    import vssr_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_SAMPLES;

    // predicts the statistics of each vector and holds results still to come
    class stats_scoreboard;
        int           store_val [STORE_DEPTH];
        bit           store_ok  [STORE_DEPTH];
        int           fill, n_ok, vmax, vmin, minpos, prev;
        longint       sum;
        longint unsigned sq, step;
        bit           rising, seen;
        int unsigned  factor, skip;
        t_result      pending_results [$];
        int           errors;

        function void clear_vector();
            fill = 0; n_ok = 0; vmax = 0; vmin = 0; minpos = 0; prev = 0;
            sum = 0; sq = 0; step = 0; rising = 1; seen = 0;
        endfunction

        function void reset_all();
            clear_vector();
            factor = FACT_RST;
            skip = SKIP_RST;
            pending_results.delete();
            errors = 0;
        endfunction

        function longint unsigned root_floor(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // spike-rejecting second pass over the stored vector
        function void clean_extremes(output int cmax, output int cmin);
            logic [127:0]    limit;
            longint          i, j, first;
            int              ref_v;
            longint unsigned ad;
            limit = 128'(factor * factor) * 128'(step);
            for (first = 0; first < fill && !store_ok[first]; first++) ;
            ref_v = store_val[first];
            cmax = ref_v;
            cmin = ref_v;
            i = first;
            while (i < fill) begin
                if (!store_ok[i]) begin
                    i++;
                end else begin
                    ad = (store_val[i] < ref_v) ? ref_v - store_val[i] : store_val[i] - ref_v;
                    if (128'(ad * ad) * 128'(n_ok) < limit) begin
                        if (store_val[i] > cmax) cmax = store_val[i];
                        else if (store_val[i] < cmin) cmin = store_val[i];
                        ref_v = store_val[i];
                        i++;
                    end else begin
                        // skip past the spike; keep the old reference if the new one is unusable
                        j = i + skip;
                        if (j < fill && store_ok[j]) ref_v = store_val[j];
                        i = j + 2;
                    end
                end
            end
        endfunction

        function void note_request(logic [SAMPLE_W-1:0] s, bit ok, bit lst);
            int              v;
            longint unsigned as, av;
            logic [127:0]    num, quo;
            t_result         r;
            int              cmax, cmin;
            longint          avg;
            longint unsigned dev, rms;
            v = int'($signed(s));
            // a full store ignores the sample, but last still closes the vector
            if (fill < STORE_DEPTH) begin
                store_val[fill] = v;
                store_ok[fill] = ok;
                fill++;
                if (ok) begin
                    if (seen) begin
                        av = (v < prev) ? prev - v : v - prev;
                        step += av * av;
                        if (v <= prev) rising = 0;
                        if (v > vmax) vmax = v;
                        if (v < vmin) vmin = v;
                    end else begin
                        vmax = v;
                        vmin = v;
                    end
                    if (v > 0 && (minpos == 0 || v < minpos)) minpos = v;
                    seen = 1;
                    prev = v;
                    n_ok++;
                    sum += v;
                    av = (v < 0) ? -v : v;
                    sq += av * av;
                end else begin
                    rising = 0;
                end
            end
            if (!lst) return;
            avg = 0;
            if (n_ok >= 2) begin
                as = (sum < 0) ? -sum : sum;
                num = 128'(n_ok) * 128'(sq) - 128'(as) * 128'(as);
                quo = num / 128'(longint'(n_ok) * (n_ok - 1));
                avg = sum / n_ok;
                dev = root_floor(quo[63:0]);
                rms = root_floor(sq / n_ok);
            end else begin
                dev = longint'(vmax) - vmin;
                rms = root_floor(sq);
            end
            cmax = 0;
            cmin = 0;
            if (n_ok > 0) clean_extremes(cmax, cmin);
            r = '0;
            r.total            = sum[SUM_W-1:0];
            r.total_squares    = sq[SQ_W-1:0];
            r.largest          = vmax[SAMPLE_W-1:0];
            r.smallest         = vmin[SAMPLE_W-1:0];
            r.least_positive   = minpos[MINPOS_W-1:0];
            r.average          = avg[SAMPLE_W-1:0];
            r.deviation        = dev[SAMPLE_W-1:0];
            r.root_mean_square = rms[RMS_W-1:0];
            r.valid_count      = n_ok[CNT_OUT_W-1:0];
            r.rising           = rising && n_ok > 0;
            r.clean_max        = cmax[SAMPLE_W-1:0];
            r.clean_min        = cmin[SAMPLE_W-1:0];
            pending_results.push_back(r);
            clear_vector();
        endfunction

        function void field_check(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, got_v);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            t_result g, e;
            g = t_result'(data[$bits(t_result)-1:0]);
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual %h", $time, g);
                return;
            end
            e = pending_results.pop_front();
            field_check("total", e.total, g.total);
            field_check("total_squares", e.total_squares, g.total_squares);
            field_check("largest", e.largest, g.largest);
            field_check("smallest", e.smallest, g.smallest);
            field_check("least_positive", e.least_positive, g.least_positive);
            field_check("average", e.average, g.average);
            field_check("deviation", e.deviation, g.deviation);
            field_check("root_mean_square", e.root_mean_square, g.root_mean_square);
            field_check("valid_count", e.valid_count, g.valid_count);
            field_check("rising", e.rising, g.rising);
            field_check("clean_max", e.clean_max, g.clean_max);
            field_check("clean_min", e.clean_min, g.clean_min);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_addr;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;   // sample[23:0], sample_valid[24]
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;   // t_result fields, total in the lowest bits

    stats_scoreboard sb;
    int              burst_left;
    int              sent;
    logic [15:0]     stall_pat;
    bit              no_stall;

    vector_stats_spike_reject_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // receiver stalls on a rotating pattern, reshuffled now and then;
    // sometimes it runs with no stall at all
    always @(negedge i_clk) begin
        stall_pat = {stall_pat[14:0], stall_pat[15]};
        if ($urandom_range(0, 199) == 0) stall_pat = $urandom;
        if ($urandom_range(0, 299) == 0) no_stall = !no_stall;
        m_axis_tready = stall_pat[0] | no_stall;
    end

    // every accepted result is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // one sample request; the sender runs in bursts with random gaps between them
    task automatic push(input logic [SAMPLE_W-1:0] s, input bit ok, input bit lst);
        if (burst_left == 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
            // long bursts give stretches with no idling
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'b0, ok, s};
        s_axis_tlast  = lst;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(s, ok, lst);
        sent++;
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // register write while idle, with room for any trailing work of the block
    task automatic write_cfg(input t_cfg_idx idx, input int unsigned value);
        drain();
        repeat (50) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == CFG_SPIKE_FACTOR) sb.factor = value & 4'hF;
        else sb.skip = value & 6'h3F;
    endtask

    // one vector with random content in one of several shapes
    task automatic random_vector(input int len);
        int shape, v, k;
        bit ok;
        shape = $urandom_range(0, 9);
        v = $signed(24'($urandom));
        if (shape < 5) v = v / 64;
        for (k = 0; k < len; k++) begin
            ok = ($urandom_range(0, 19) != 0);
            case (shape)
                0, 1, 2, 3, 4: begin
                    // smooth walk with an occasional spike
                    v += $signed(10'($urandom));
                    if (v > 8000000) v = 8000000;
                    if (v < -8000000) v = -8000000;
                    if ($urandom_range(0, 11) == 0)
                        push(24'(v + $signed(20'($urandom)) * 8), ok, k == len - 1);
                    else
                        push(24'(v), ok, k == len - 1);
                end
                5, 6: push(24'($urandom), ok, k == len - 1);
                7: begin
                    // rising walk that may repeat a value and wraps at the top, mostly all valid
                    v += $urandom_range(0, 50);
                    if (v > 8388607) v = -8388608;
                    push(24'(v), ok | ($urandom_range(0, 3) != 0), k == len - 1);
                end
                8: push(24'(v), ok, k == len - 1);   // flat: zero step energy
                default: push(24'($urandom), $urandom_range(0, 3) == 0, k == len - 1);
            endcase
        end
    endtask

    task automatic random_phase(input int items);
        int stop_at;
        stop_at = sent + items;
        while (sent < stop_at) begin
            random_vector(($urandom_range(0, 7) == 0) ? $urandom_range(25, 150)
                                                      : $urandom_range(1, 24));
            // now and then the sender holds off until the block has answered everything
            if ($urandom_range(0, 5) == 0) drain();
        end
    endtask

    // give up after a generous fixed time
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        sb = new();
        sb.reset_all();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_SPIKE_FACTOR;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        stall_pat     = 16'hA5C3;
        no_stall      = 1'b0;
        burst_left    = 0;
        sent          = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, n below two, no valid sample, flat vector, spikes
        push(24'h7FFFFF, 1, 0);
        push(24'h800000, 1, 1);
        push(-24'sd5, 1, 1);
        push(24'h123456, 0, 0);
        push(24'hFFFFFF, 0, 1);
        push(24'd3, 1, 0);
        push(24'd3, 1, 0);
        push(24'd3, 1, 1);
        write_cfg(CFG_SKIP_LENGTH, 1);
        write_cfg(CFG_SPIKE_FACTOR, 1);
        // spike, then an invalid sample where the new reference would be
        push(24'd0, 1, 0);
        push(24'd1, 1, 0);
        push(24'd200000, 1, 0);
        push(24'd2, 0, 0);
        push(24'd3, 1, 0);
        push(24'd4, 1, 0);
        push(24'd5, 1, 1);
        // spike near the end: the new reference lies beyond the vector
        push(24'd10, 1, 0);
        push(24'd11, 1, 0);
        push(-24'sd90000, 1, 1);
        // invalid leading sample, then rising
        push(24'd7, 0, 0);
        push(24'd8, 1, 0);
        push(24'd9, 1, 1);

        write_cfg(CFG_SPIKE_FACTOR, 15);
        write_cfg(CFG_SKIP_LENGTH, 63);
        random_phase(250);
        write_cfg(CFG_SPIKE_FACTOR, 1);
        write_cfg(CFG_SKIP_LENGTH, 0);
        random_phase(250);
        write_cfg(CFG_SPIKE_FACTOR, 15);
        random_phase(250);
        write_cfg(CFG_SPIKE_FACTOR, 7);
        write_cfg(CFG_SKIP_LENGTH, 20);
        random_phase(250);

        write_cfg(CFG_SPIKE_FACTOR, $urandom_range(1, 15));
        write_cfg(CFG_SKIP_LENGTH, $urandom_range(0, 63));
        random_phase(350);
        write_cfg(CFG_SPIKE_FACTOR, $urandom_range(1, 15));
        write_cfg(CFG_SKIP_LENGTH, $urandom_range(0, 63));
        random_phase(350);

        drain();
        repeat (500) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
